### sv/pipmap_pkg.sv
// Package for the picture-in-picture pixel source map.
// Holds widths, register indexes, reset values, overlay geometry defaults and result kind codes.
// No dependencies.
`timescale 1ns / 1ps

package pipmap_pkg;

  // Width of every configuration register and of the input coordinates.
  localparam int CFG_W   = 13;
  localparam int COORD_W = 12;
  localparam int IDX_W   = 3;
  localparam int KIND_W  = 2;

  // Overlay geometry defaults.
  localparam int BOX_SIZE_DEF     = 240;
  localparam int BOX_INSET_DEF    = 24;
  localparam int BORDER_WIDTH_DEF = 4;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd2;
  localparam logic [IDX_W-1:0] REG_CROP_LEFT     = 3'd3;
  localparam logic [IDX_W-1:0] REG_CROP_TOP      = 3'd4;
  localparam logic [IDX_W-1:0] REG_CAMERA_WIDTH  = 3'd5;
  localparam logic [IDX_W-1:0] REG_CAMERA_HEIGHT = 3'd6;

  // Register reset values.
  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH   = 13'd1920;
  localparam logic [CFG_W-1:0] RST_WINDOW_WIDTH  = 13'd1920;
  localparam logic [CFG_W-1:0] RST_WINDOW_HEIGHT = 13'd1080;
  localparam logic [CFG_W-1:0] RST_CROP_LEFT     = 13'd0;
  localparam logic [CFG_W-1:0] RST_CROP_TOP      = 13'd0;
  localparam logic [CFG_W-1:0] RST_CAMERA_WIDTH  = 13'd0;
  localparam logic [CFG_W-1:0] RST_CAMERA_HEIGHT = 13'd480;

  // Source kind codes.
  localparam logic [KIND_W-1:0] KIND_WINDOW = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BORDER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CAMERA = 2'd2;

endpackage

### sv/pip_overlay_pixel_source_map.sv
// Top level of the picture-in-picture pixel source map: a five-register pipeline.
// Depends on pipmap_pkg for register indexes, reset values and kind codes.
`timescale 1ns / 1ps

// The block takes one output pixel coordinate per clock cycle and returns, through
// the input register, three work stages (offsets, products, reciprocal multiply for
// the division by the box size) and the output register, where that pixel's color
// comes from: the cropped window, the overlay border, or the scaled camera picture.
// busy_o is always low, so a coordinate can be started in every cycle; the rate is
// one pixel per cycle. done_o marks each result for exactly one cycle and results
// cannot be held off, so the receiver must take every beat as it comes. The user
// must write the configuration registers through cfg_we_i, cfg_idx_i and
// cfg_wdata_i only while no pixel is in flight; the block itself does not enforce
// this.
module pip_overlay_pixel_source_map #(
  parameter int BOX_SIZE     = pipmap_pkg::BOX_SIZE_DEF,
  parameter int BOX_INSET    = pipmap_pkg::BOX_INSET_DEF,
  parameter int BORDER_WIDTH = pipmap_pkg::BORDER_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [pipmap_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [pipmap_pkg::CFG_W-1:0]    cfg_wdata_i,
  // Command side
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [pipmap_pkg::COORD_W-1:0]  out_x_i,
  input  logic [pipmap_pkg::COORD_W-1:0]  out_y_i,
  // Result side
  output logic                            done_o,
  output logic [pipmap_pkg::KIND_W-1:0]   source_kind_o,
  output logic [pipmap_pkg::COORD_W-1:0]  source_x_o,
  output logic [pipmap_pkg::COORD_W-1:0]  source_y_o
);

  localparam int CFG_W   = pipmap_pkg::CFG_W;
  localparam int COORD_W = pipmap_pkg::COORD_W;
  localparam int KIND_W  = pipmap_pkg::KIND_W;

  // Signed width for box-relative coordinates.
  localparam int CW = 16;

  // Box index width, product width and the reciprocal used to divide by BOX_SIZE.
  // With SHIFT = PW + BXW the truncated product is exact for every product below 2**PW.
  localparam int BXW   = $clog2(BOX_SIZE);
  localparam int PW    = BXW + CFG_W;
  localparam int SHIFT = PW + BXW;
  localparam int MW    = PW + 2;
  localparam int RW    = PW + MW;
  localparam logic [63:0] RECIP_WIDE = ((64'd1 << SHIFT) + 64'(BOX_SIZE) - 64'd1) / BOX_SIZE;
  localparam logic [MW-1:0] RECIP = RECIP_WIDE[MW-1:0];

  localparam logic signed [CW-1:0] X0_OFF   = CW'(BOX_INSET + BOX_SIZE);
  localparam logic signed [CW-1:0] INSET_S  = CW'(BOX_INSET);
  localparam logic signed [CW-1:0] SIZE_S   = CW'(BOX_SIZE);
  localparam logic signed [CW-1:0] OUTER_LO = -CW'(BORDER_WIDTH);
  localparam logic signed [CW-1:0] OUTER_HI = CW'(BOX_SIZE + BORDER_WIDTH);

  // Clamp a non-negative coordinate below a limit; a zero limit gives 0.
  // The result saturates at the largest 12-bit coordinate.
  function automatic logic [COORD_W-1:0] clamp_coord(input logic [13:0] v,
                                                     input logic [CFG_W-1:0] n);
    logic [13:0] r;
    r = v;
    if (n == '0) begin
      r = '0;
    end else if (v >= {1'b0, n}) begin
      r = {1'b0, n} - 14'd1;
    end
    if (r > 14'd4095) begin
      r = 14'd4095;
    end
    return r[COORD_W-1:0];
  endfunction

  // Configuration registers.
  logic [CFG_W-1:0] frame_width_q, window_width_q, window_height_q;
  logic [CFG_W-1:0] crop_left_q, crop_top_q, camera_width_q, camera_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= pipmap_pkg::RST_FRAME_WIDTH;
      window_width_q  <= pipmap_pkg::RST_WINDOW_WIDTH;
      window_height_q <= pipmap_pkg::RST_WINDOW_HEIGHT;
      crop_left_q     <= pipmap_pkg::RST_CROP_LEFT;
      crop_top_q      <= pipmap_pkg::RST_CROP_TOP;
      camera_width_q  <= pipmap_pkg::RST_CAMERA_WIDTH;
      camera_height_q <= pipmap_pkg::RST_CAMERA_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pipmap_pkg::REG_FRAME_WIDTH:   frame_width_q   <= cfg_wdata_i;
        pipmap_pkg::REG_WINDOW_WIDTH:  window_width_q  <= cfg_wdata_i;
        pipmap_pkg::REG_WINDOW_HEIGHT: window_height_q <= cfg_wdata_i;
        pipmap_pkg::REG_CROP_LEFT:     crop_left_q     <= cfg_wdata_i;
        pipmap_pkg::REG_CROP_TOP:      crop_top_q      <= cfg_wdata_i;
        pipmap_pkg::REG_CAMERA_WIDTH:  camera_width_q  <= cfg_wdata_i;
        pipmap_pkg::REG_CAMERA_HEIGHT: camera_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so a new beat is taken in every cycle.
  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage A: input register.
  logic               a_vld_q;
  logic [COORD_W-1:0] a_x_q, a_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    a_x_q <= out_x_i;
    a_y_q <= out_y_i;
  end

  // ---------------------------------------------------------------------------
  // Stage B: crop offsets, box-relative coordinates and the camera crop square.
  logic [COORD_W-1:0]   crop_x, crop_y;
  logic [CFG_W-1:0]     fw_even, fw;
  logic signed [CW-1:0] box_x0;
  logic [CFG_W-1:0]     b_sx_raw_d, b_sy_raw_d, b_sq_d;
  logic signed [CW-1:0] b_bx_d, b_by_d;
  logic [COORD_W-1:0]   b_half_d;
  logic [CFG_W-1:0]     cam_diff;

  always_comb begin
    // Negative crop offsets act as zero.
    crop_x     = crop_left_q[CFG_W-1] ? '0 : crop_left_q[COORD_W-1:0];
    crop_y     = crop_top_q[CFG_W-1] ? '0 : crop_top_q[COORD_W-1:0];
    b_sx_raw_d = CFG_W'(a_x_q) + CFG_W'(crop_x);
    b_sy_raw_d = CFG_W'(a_y_q) + CFG_W'(crop_y);

    // Frame width rounded down to even, at least 2.
    fw_even = {frame_width_q[CFG_W-1:1], 1'b0};
    fw      = (fw_even < 13'd2) ? 13'd2 : fw_even;
    box_x0  = $signed(CW'(fw)) - X0_OFF;
    b_bx_d  = $signed(CW'(a_x_q)) - box_x0;
    b_by_d  = $signed(CW'(a_y_q)) - INSET_S;

    // Centered square crop of the camera frame.
    b_sq_d   = (camera_width_q < camera_height_q) ? camera_width_q : camera_height_q;
    cam_diff = camera_width_q - b_sq_d;
    b_half_d = cam_diff[CFG_W-1:1];
  end

  logic                 b_vld_q;
  logic [CFG_W-1:0]     b_sx_raw_q, b_sy_raw_q, b_sq_q;
  logic signed [CW-1:0] b_bx_q, b_by_q;
  logic [COORD_W-1:0]   b_half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_sx_raw_q <= b_sx_raw_d;
    b_sy_raw_q <= b_sy_raw_d;
    b_bx_q     <= b_bx_d;
    b_by_q     <= b_by_d;
    b_sq_q     <= b_sq_d;
    b_half_q   <= b_half_d;
  end

  // ---------------------------------------------------------------------------
  // Stage C: region decision, window clamp and the scaling products.
  logic               in_outer, in_inner;
  logic [KIND_W-1:0]  c_kind_d;
  logic [COORD_W-1:0] c_wx_d, c_wy_d;
  logic [PW-1:0]      c_px_d, c_py_d;

  always_comb begin
    in_outer = (b_bx_q >= OUTER_LO) && (b_bx_q < OUTER_HI) &&
               (b_by_q >= OUTER_LO) && (b_by_q < OUTER_HI);
    // Inside the box means a non-negative offset below the box size on both axes.
    in_inner = !b_bx_q[CW-1] && (b_bx_q < SIZE_S) &&
               !b_by_q[CW-1] && (b_by_q < SIZE_S);

    if ((camera_width_q != '0) && in_outer) begin
      c_kind_d = in_inner ? pipmap_pkg::KIND_CAMERA : pipmap_pkg::KIND_BORDER;
    end else begin
      c_kind_d = pipmap_pkg::KIND_WINDOW;
    end

    c_wx_d = clamp_coord({1'b0, b_sx_raw_q}, window_width_q);
    c_wy_d = clamp_coord({1'b0, b_sy_raw_q}, window_height_q);

    // Box index times crop size; only used inside the box.
    c_px_d = PW'(b_bx_q[BXW-1:0]) * PW'(b_sq_q);
    c_py_d = PW'(b_by_q[BXW-1:0]) * PW'(b_sq_q);
  end

  logic               c_vld_q;
  logic [KIND_W-1:0]  c_kind_q;
  logic [COORD_W-1:0] c_wx_q, c_wy_q, c_half_q;
  logic [PW-1:0]      c_px_q, c_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_kind_q <= c_kind_d;
    c_wx_q   <= c_wx_d;
    c_wy_q   <= c_wy_d;
    c_px_q   <= c_px_d;
    c_py_q   <= c_py_d;
    c_half_q <= b_half_q;
  end

  // ---------------------------------------------------------------------------
  // Stage D: divide the products by the box size through a reciprocal multiply.
  logic [RW-1:0]    prod_x, prod_y;
  logic [CFG_W-1:0] d_qx_d, d_qy_d;

  always_comb begin
    prod_x = RW'(c_px_q) * RW'(RECIP);
    prod_y = RW'(c_py_q) * RW'(RECIP);
    d_qx_d = prod_x[SHIFT +: CFG_W];
    d_qy_d = prod_y[SHIFT +: CFG_W];
  end

  logic               d_vld_q;
  logic [KIND_W-1:0]  d_kind_q;
  logic [COORD_W-1:0] d_wx_q, d_wy_q, d_half_q;
  logic [CFG_W-1:0]   d_qx_q, d_qy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_kind_q <= c_kind_q;
    d_wx_q   <= c_wx_q;
    d_wy_q   <= c_wy_q;
    d_half_q <= c_half_q;
    d_qx_q   <= d_qx_d;
    d_qy_q   <= d_qy_d;
  end

  // ---------------------------------------------------------------------------
  // Output stage: camera offset and clamp, then the final selection.
  logic [13:0]        cam_cx;
  logic [COORD_W-1:0] cam_x, cam_y;
  logic [COORD_W-1:0] src_x_d, src_y_d;

  always_comb begin
    cam_cx = 14'(d_half_q) + 14'(d_qx_q);
    cam_x  = clamp_coord(cam_cx, camera_width_q);
    cam_y  = clamp_coord(14'(d_qy_q), camera_height_q);

    case (d_kind_q)
      pipmap_pkg::KIND_WINDOW: begin
        src_x_d = d_wx_q;
        src_y_d = d_wy_q;
      end
      pipmap_pkg::KIND_CAMERA: begin
        src_x_d = cam_x;
        src_y_d = cam_y;
      end
      default: begin
        src_x_d = '0;
        src_y_d = '0;
      end
    endcase
  end

  logic               done_q;
  logic [KIND_W-1:0]  kind_q;
  logic [COORD_W-1:0] src_x_q, src_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= d_kind_q;
    src_x_q <= src_x_d;
    src_y_q <= src_y_d;
  end

  assign done_o        = done_q;
  assign source_kind_o = kind_q;
  assign source_x_o    = src_x_q;
  assign source_y_o    = src_y_q;

endmodule

### dv/tb_top.sv
// Testbench for the picture-in-picture pixel source map: directed and random pixels
// checked against a behavioral mapping model kept in this file.
// Depends on pipmap_pkg and on the pip_overlay_pixel_source_map RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int CFG_W       = pipmap_pkg::CFG_W;
  localparam int COORD_W     = pipmap_pkg::COORD_W;
  localparam int IDX_W       = pipmap_pkg::IDX_W;
  localparam int KIND_W      = pipmap_pkg::KIND_W;
  localparam int LATENCY     = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int COORD_MAX   = (1 << COORD_W) - 1;
  localparam int BOX         = pipmap_pkg::BOX_SIZE_DEF;
  localparam int INSET       = pipmap_pkg::BOX_INSET_DEF;
  localparam int BORDER      = pipmap_pkg::BORDER_WIDTH_DEF;
  localparam int NUM_REGS    = 7;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
  } pixel_source_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [IDX_W-1:0]    cfg_idx_i;
  logic [CFG_W-1:0]    cfg_wdata_i;
  logic                start_i;
  logic                busy_o;
  logic [COORD_W-1:0]  out_x_i;
  logic [COORD_W-1:0]  out_y_i;
  logic                done_o;
  logic [KIND_W-1:0]   source_kind_o;
  logic [COORD_W-1:0]  source_x_o;
  logic [COORD_W-1:0]  source_y_o;

  // Local copy of the configuration registers, indexed by register name.
  logic [CFG_W-1:0] cfg_shadow [NUM_REGS];

  pixel_source_t mapped_pixels [$];
  int            fail_count;
  int            pixels_sent;
  int            settings_used;
  int            cycle_count;
  int            kind_seen [3];

  pip_overlay_pixel_source_map u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .out_x_i       (out_x_i),
    .out_y_i       (out_y_i),
    .done_o        (done_o),
    .source_kind_o (source_kind_o),
    .source_x_o    (source_x_o),
    .source_y_o    (source_y_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run guard: a hung block ends the run as a failure.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, mapped_pixels.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Even frame width with a floor of 2, as the box placement uses it.
  function automatic int frame_even();
    int fw;
    fw = int'(cfg_shadow[pipmap_pkg::REG_FRAME_WIDTH]) & ~1;
    if (fw < 2) fw = 2;
    return fw;
  endfunction

  function automatic int clamp_coord(int v, int hi);
    int r;
    r = v;
    if (r > hi) r = hi;
    if (r < 0) r = 0;
    if (r > COORD_MAX) r = COORD_MAX;
    return r;
  endfunction

  // Works out where one output pixel takes its color from under the current settings.
  function automatic pixel_source_t map_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    pixel_source_t res;
    int cl, ct, sx, sy, bx, by, cw, ch, sq, cx, cy;
    cl = int'($signed(cfg_shadow[pipmap_pkg::REG_CROP_LEFT]));
    ct = int'($signed(cfg_shadow[pipmap_pkg::REG_CROP_TOP]));
    if (cl < 0) cl = 0;
    if (ct < 0) ct = 0;
    res.kind = pipmap_pkg::KIND_WINDOW;
    sx = clamp_coord(cl + int'(x), int'(cfg_shadow[pipmap_pkg::REG_WINDOW_WIDTH]) - 1);
    sy = clamp_coord(ct + int'(y), int'(cfg_shadow[pipmap_pkg::REG_WINDOW_HEIGHT]) - 1);
    cw = int'(cfg_shadow[pipmap_pkg::REG_CAMERA_WIDTH]);
    ch = int'(cfg_shadow[pipmap_pkg::REG_CAMERA_HEIGHT]);
    if (cw != 0) begin
      bx = int'(x) - (frame_even() - INSET - BOX);
      by = int'(y) - INSET;
      if (bx >= -BORDER && bx < BOX + BORDER && by >= -BORDER && by < BOX + BORDER) begin
        if (bx < 0 || bx >= BOX || by < 0 || by >= BOX) begin
          res.kind = pipmap_pkg::KIND_BORDER;
          sx = 0;
          sy = 0;
        end else begin
          // Centered square crop of the camera, nearest neighbor scaling.
          sq = (cw < ch) ? cw : ch;
          cx = (cw - sq) / 2 + bx * sq / BOX;
          cy = by * sq / BOX;
          res.kind = pipmap_pkg::KIND_CAMERA;
          sx = clamp_coord(cx, cw - 1);
          sy = clamp_coord(cy, ch - 1);
        end
      end
    end
    res.sx = sx[COORD_W-1:0];
    res.sy = sy[COORD_W-1:0];
    return res;
  endfunction

  // Result checker: every done beat must match the oldest predicted source.
  always @(posedge clk_i) begin : check_results
    pixel_source_t want;
    if (rst_ni && done_o) begin
      if (mapped_pixels.size() == 0) begin
        $error("Result beat with nothing expected: kind %0d x %0d y %0d",
               source_kind_o, source_x_o, source_y_o);
        fail_count++;
      end else begin
        want = mapped_pixels.pop_front();
        if (want.kind < 3) kind_seen[want.kind]++;
        if (source_kind_o !== want.kind) begin
          $error("source_kind: expected %0d, actual %0d", want.kind, source_kind_o);
          fail_count++;
        end
        if (source_x_o !== want.sx) begin
          $error("source_x: expected %0d, actual %0d", want.sx, source_x_o);
          fail_count++;
        end
        if (source_y_o !== want.sy) begin
          $error("source_y: expected %0d, actual %0d", want.sy, source_y_o);
          fail_count++;
        end
      end
    end
  end

  // Offers one pixel and holds it until the block takes the beat.
  task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    start_i <= 1'b1;
    out_x_i <= x;
    out_y_i <= y;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    mapped_pixels.push_back(map_pixel(x, y));
    pixels_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    start_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Holds off until every predicted result has come back and the pipeline is empty.
  task automatic wait_for_results();
    start_i <= 1'b0;
    while (mapped_pixels.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // Writes all seven registers back to back while the block is idle.
  task automatic apply_config(input int fw, input int ww, input int wh, input int cl,
                              input int ct, input int cw, input int ch);
    logic [CFG_W-1:0] vals [NUM_REGS];
    vals[pipmap_pkg::REG_FRAME_WIDTH]   = fw[CFG_W-1:0];
    vals[pipmap_pkg::REG_WINDOW_WIDTH]  = ww[CFG_W-1:0];
    vals[pipmap_pkg::REG_WINDOW_HEIGHT] = wh[CFG_W-1:0];
    vals[pipmap_pkg::REG_CROP_LEFT]     = cl[CFG_W-1:0];
    vals[pipmap_pkg::REG_CROP_TOP]      = ct[CFG_W-1:0];
    vals[pipmap_pkg::REG_CAMERA_WIDTH]  = cw[CFG_W-1:0];
    vals[pipmap_pkg::REG_CAMERA_HEIGHT] = ch[CFG_W-1:0];
    wait_for_results();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= i[IDX_W-1:0];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    cfg_shadow = vals;
    settings_used++;
  endtask

  // Sizes lean toward the legal range, with its ends and full 13-bit values mixed in.
  function automatic int rand_size(int lo, int hi);
    case ($urandom_range(0, 9))
      0:       return lo;
      1:       return hi;
      2:       return int'($urandom_range(0, (1 << CFG_W) - 1));
      default: return int'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic int rand_crop();
    case ($urandom_range(0, 7))
      0:       return -4096;
      1:       return 4095;
      2:       return -int'($urandom_range(1, 4096));
      3:       return int'($urandom_range(0, 4095));
      default: return int'($urandom_range(0, 200));
    endcase
  endfunction

  task automatic apply_random_config();
    int fw, cw;
    fw = ($urandom_range(0, 3) == 0) ? rand_size(2, 4096) : int'($urandom_range(264, 4096));
    cw = ($urandom_range(0, 4) == 0) ? 0 : rand_size(1, 4096);
    apply_config(fw, rand_size(1, 4096), rand_size(1, 4096), rand_crop(), rand_crop(),
                 cw, rand_size(1, 4096));
  endtask

  // Two in five pixels aim around the overlay box so border and camera cases show up often.
  task automatic send_random_pixel();
    int px, py;
    if ($urandom_range(0, 4) < 2) begin
      px = frame_even() - INSET - BOX - BORDER - 2 +
           int'($urandom_range(0, BOX + 2 * BORDER + 3));
      py = INSET - BORDER - 2 + int'($urandom_range(0, BOX + 2 * BORDER + 3));
      if (px < 0 || px > COORD_MAX) px = int'($urandom_range(0, COORD_MAX));
    end else begin
      px = int'($urandom_range(0, COORD_MAX));
      py = int'($urandom_range(0, COORD_MAX));
    end
    send_pixel(px[COORD_W-1:0], py[COORD_W-1:0]);
  endtask

  // Reset settings: no camera, so every pixel maps into the window.
  task automatic test_window_only();
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(1919, 1079);
    send_pixel(1920, 1080);
    send_pixel(0, 12'hFFF);
    send_pixel(12'hFFF, 0);
  endtask

  // Camera on with a 1920 frame: step across each edge of the border and box.
  task automatic test_overlay_edges();
    apply_config(1920, 1920, 1080, 0, 0, 640, 480);
    send_pixel(1651, 100);
    send_pixel(1652, 100);
    send_pixel(1656, 24);
    send_pixel(1895, 263);
    send_pixel(1896, 263);
    send_pixel(1899, 267);
    send_pixel(1900, 268);
    send_pixel(1656, 19);
  endtask

  // Zero window and camera sizes, negative crops, odd and tiny frame widths.
  task automatic test_degenerate_sizes();
    apply_config(1, 0, 0, -4096, -1, 1, 0);
    send_pixel(0, 0);
    send_pixel(12'hFFF, 12'hFFF);
    apply_config(301, 1, 1, -1, 4095, 1, 0);
    send_pixel(35, 100);
    send_pixel(36, 24);
    send_pixel(275, 263);
    send_pixel(32, 20);
  endtask

  // Registers beyond the 12-bit coordinate range make source coordinates saturate.
  task automatic test_oversized_registers();
    apply_config(4096, 8191, 8191, 4095, 4095, 8191, 8191);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(4071, 263);
    send_pixel(3832, 24);
    send_pixel(3831, 24);
    send_pixel(0, 0);
  endtask

  // Random settings, each with a run of pixels and random sender gaps.
  // The last pixel of a run is followed by the drain of the next settings change.
  task automatic test_random_mappings();
    int gap_rate;
    for (int p = 0; p < 10; p++) begin
      apply_random_config();
      gap_rate = int'($urandom_range(0, 3));
      for (int n = 0; n < 100; n++) begin
        send_random_pixel();
        if (int'($urandom_range(0, 3)) < gap_rate) pause_sender(int'($urandom_range(1, 7)));
        if (n < 99 && $urandom_range(0, 49) == 0) wait_for_results();
      end
    end
  endtask

  // Closing stretch: one beat every cycle, no gaps.
  task automatic test_back_to_back();
    apply_random_config();
    repeat (120) send_random_pixel();
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = pipmap_pkg::REG_FRAME_WIDTH;
    cfg_wdata_i = '0;
    start_i     = 1'b0;
    out_x_i     = '0;
    out_y_i     = '0;
    fail_count  = 0;
    pixels_sent = 0;
    settings_used = 1;
    kind_seen   = '{0, 0, 0};
    cfg_shadow[pipmap_pkg::REG_FRAME_WIDTH]   = pipmap_pkg::RST_FRAME_WIDTH;
    cfg_shadow[pipmap_pkg::REG_WINDOW_WIDTH]  = pipmap_pkg::RST_WINDOW_WIDTH;
    cfg_shadow[pipmap_pkg::REG_WINDOW_HEIGHT] = pipmap_pkg::RST_WINDOW_HEIGHT;
    cfg_shadow[pipmap_pkg::REG_CROP_LEFT]     = pipmap_pkg::RST_CROP_LEFT;
    cfg_shadow[pipmap_pkg::REG_CROP_TOP]      = pipmap_pkg::RST_CROP_TOP;
    cfg_shadow[pipmap_pkg::REG_CAMERA_WIDTH]  = pipmap_pkg::RST_CAMERA_WIDTH;
    cfg_shadow[pipmap_pkg::REG_CAMERA_HEIGHT] = pipmap_pkg::RST_CAMERA_HEIGHT;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_window_only();
    test_overlay_edges();
    test_degenerate_sizes();
    test_oversized_registers();
    test_random_mappings();
    test_back_to_back();
    wait_for_results();

    $display("Mapped %0d pixels under %0d register settings.", pixels_sent, settings_used);
    $display("Results seen: %0d window, %0d border, %0d camera; %0d mismatches.",
             kind_seen[pipmap_pkg::KIND_WINDOW], kind_seen[pipmap_pkg::KIND_BORDER],
             kind_seen[pipmap_pkg::KIND_CAMERA], fail_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
sv/pipmap_pkg.sv
sv/pip_overlay_pixel_source_map.sv
dv/tb_top.sv
